/* hdl/tvf_pkg.sv */
// Shared types, constants and state codes of the trilinear vector field lookup.
`timescale 1ns / 1ps
package tvf_pkg;

  localparam int VAL_W   = 32;
  localparam int ADDR_W  = 18;
  localparam int IDX_W   = 10;
  localparam int FRAC_W  = 17;
  localparam int CFG_IW  = 3;
  localparam int ACC_W   = 66;
  localparam int STORE_D = 1 << ADDR_W;
  localparam int QDEPTH  = 2;

  localparam int DEF_NODES_X = 64;
  localparam int DEF_NODES_Y = 64;
  localparam int DEF_NODES_Z = 64;

  localparam logic [FRAC_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [VAL_W-1:0]  INV_STEP_RST = 32'h0001_0000;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [CFG_IW-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_INV_STEP_X = 3'd3,
    REG_INV_STEP_Y = 3'd4,
    REG_INV_STEP_Z = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_CLAMP,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_RUN,
    BS_DRAIN
  } back_state_t;

  typedef struct packed {
    logic                     func;
    logic [ADDR_W-1:0]        node_addr;
    logic [2:0][VAL_W-1:0]    val;
    logic [2:0][IDX_W-1:0]    lo;
    logic [2:0][FRAC_W-1:0]   frac;
  } req_t;

endpackage

/* hdl/trilinear_vector_field_lookup_top.sv */
// Top level of the trilinear vector field lookup.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------------
//   config   | cfg_we                  | cfg_index, cfg_wdata
//   request  | start && !busy          | func, node_addr, load_v*, pos_*
//   result   | done (one cycle)        | field_x, field_y, field_z
//
// A load request goes from capture straight to the push state in the front and makes
// one grid store write in the back. A query takes one multiply and one clamp per axis
// in the front and eight reads of the single-port grid store plus the weight and
// accumulate pipeline in the back; the front takes the next request meanwhile.
// Synchronous reset clears control and loads the configuration defaults; the grid
// store is not cleared. The receiver cannot stall; done pulses once per query.
`timescale 1ns / 1ps
module trilinear_vector_field_lookup_top
  import tvf_pkg::*;
#(
  parameter int NODES_X = DEF_NODES_X,
  parameter int NODES_Y = DEF_NODES_Y,
  parameter int NODES_Z = DEF_NODES_Z
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [VAL_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [ADDR_W-1:0] node_addr,
  input  logic [VAL_W-1:0]  load_vx,
  input  logic [VAL_W-1:0]  load_vy,
  input  logic [VAL_W-1:0]  load_vz,
  input  logic [VAL_W-1:0]  pos_x,
  input  logic [VAL_W-1:0]  pos_y,
  input  logic [VAL_W-1:0]  pos_z,
  output logic              done,
  output logic [VAL_W-1:0]  field_x,
  output logic [VAL_W-1:0]  field_y,
  output logic [VAL_W-1:0]  field_z
);

  logic q_push, q_pop, q_empty, q_full;
  req_t q_req, q_head;

  tvf_front #(
    .NODES_X (NODES_X),
    .NODES_Y (NODES_Y),
    .NODES_Z (NODES_Z)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .node_addr (node_addr),
    .load_vx   (load_vx),
    .load_vy   (load_vy),
    .load_vz   (load_vz),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (q_req)
  );

  tvf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (q_req),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tvf_back #(
    .NODES_X (NODES_X),
    .NODES_Y (NODES_Y),
    .NODES_Z (NODES_Z)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .done    (done),
    .field_x (field_x),
    .field_y (field_y),
    .field_z (field_z)
  );

endmodule

/* hdl/tvf_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tvf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/tvf_queue.sv */
// Short request queue between the front and back parts.
`timescale 1ns / 1ps
module tvf_queue
  import tvf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output req_t head,
  output logic empty,
  output logic full
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  req_t           slots [QDEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [PW:0]    count;

  assign head  = slots[rptr];
  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_req;
    end
  end

endmodule

/* hdl/tvf_front.sv */
// Front part: configuration registers, request capture and per-axis index and fraction.
`timescale 1ns / 1ps
module tvf_front
  import tvf_pkg::*;
#(
  parameter int NODES_X = DEF_NODES_X,
  parameter int NODES_Y = DEF_NODES_Y,
  parameter int NODES_Z = DEF_NODES_Z
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [VAL_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [ADDR_W-1:0] node_addr,
  input  logic [VAL_W-1:0]  load_vx,
  input  logic [VAL_W-1:0]  load_vy,
  input  logic [VAL_W-1:0]  load_vz,
  input  logic [VAL_W-1:0]  pos_x,
  input  logic [VAL_W-1:0]  pos_y,
  input  logic [VAL_W-1:0]  pos_z,
  input  logic              q_full,
  output logic              q_push,
  output req_t              q_req
);

  localparam logic [IDX_W-1:0] NMAX_X = IDX_W'(NODES_X - 1);
  localparam logic [IDX_W-1:0] NMAX_Y = IDX_W'(NODES_Y - 1);
  localparam logic [IDX_W-1:0] NMAX_Z = IDX_W'(NODES_Z - 1);

  front_state_t state, state_next;

  logic [VAL_W-1:0]       origin   [3];
  logic [VAL_W-1:0]       inv_step [3];
  logic [VAL_W-1:0]       pos      [3];
  logic [1:0]             ax;
  logic [2*VAL_W-1:0]     prod;
  req_t                   req;

  logic                   accept;
  logic signed [VAL_W:0]  diff;
  logic [IDX_W-1:0]       nmax;
  logic [47:0]            fi;
  logic [47:0]            cap;
  logic [47:0]            fc;
  logic [IDX_W-1:0]       lo_c;
  logic [IDX_W-1:0]       lo_v;
  logic [FRAC_W-1:0]      frac_v;

  assign accept = start && (state == FS_IDLE);
  assign busy   = (state != FS_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE:  if (start) state_next = (func == FUNC_QUERY) ? FS_MUL : FS_PUSH;
      FS_MUL:   state_next = FS_CLAMP;
      FS_CLAMP: state_next = (ax == 2'd2) ? FS_PUSH : FS_MUL;
      FS_PUSH:  if (!q_full) state_next = FS_IDLE;
      default:  state_next = FS_IDLE;
    endcase
  end

  always_comb begin
    q_push = (state == FS_PUSH) && !q_full;
    q_req  = req;
  end

  always_comb begin
    unique case (ax)
      2'd0:    nmax = NMAX_X;
      2'd1:    nmax = NMAX_Y;
      default: nmax = NMAX_Z;
    endcase
    diff   = $signed({pos[ax][VAL_W-1], pos[ax]}) - $signed({origin[ax][VAL_W-1], origin[ax]});
    fi     = prod[63:16];
    cap    = {22'd0, nmax, 16'd0};
    fc     = (fi > cap) ? cap : fi;
    lo_c   = fc[16 +: IDX_W];
    if ({1'b0, lo_c} + 11'd1 > {1'b0, nmax}) begin
      lo_v = (nmax >= IDX_W'(1)) ? nmax - 1'b1 : '0;
    end else begin
      lo_v = lo_c;
    end
    frac_v = FRAC_W'(fc[26:0] - {1'b0, lo_v, 16'd0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FS_IDLE;
      origin[0]   <= '0;
      origin[1]   <= '0;
      origin[2]   <= '0;
      inv_step[0] <= INV_STEP_RST;
      inv_step[1] <= INV_STEP_RST;
      inv_step[2] <= INV_STEP_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ORIGIN_X:   origin[0]   <= cfg_wdata;
          REG_ORIGIN_Y:   origin[1]   <= cfg_wdata;
          REG_ORIGIN_Z:   origin[2]   <= cfg_wdata;
          REG_INV_STEP_X: inv_step[0] <= cfg_wdata;
          REG_INV_STEP_Y: inv_step[1] <= cfg_wdata;
          REG_INV_STEP_Z: inv_step[2] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.func      <= func;
      req.node_addr <= node_addr;
      req.val[0]    <= load_vx;
      req.val[1]    <= load_vy;
      req.val[2]    <= load_vz;
      pos[0]        <= pos_x;
      pos[1]        <= pos_y;
      pos[2]        <= pos_z;
      ax            <= 2'd0;
    end
    if (state == FS_MUL) begin
      prod <= (diff > 0) ? diff[VAL_W-1:0] * inv_step[ax] : '0;
    end
    if (state == FS_CLAMP) begin
      req.lo[ax]   <= lo_v;
      req.frac[ax] <= frac_v;
      ax           <= ax + 2'd1;
    end
  end

endmodule

/* hdl/tvf_back.sv */
// Back part: grid store writes and eight-corner trilinear accumulation.
`timescale 1ns / 1ps
module tvf_back
  import tvf_pkg::*;
#(
  parameter int NODES_X = DEF_NODES_X,
  parameter int NODES_Y = DEF_NODES_Y,
  parameter int NODES_Z = DEF_NODES_Z
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             done,
  output logic [VAL_W-1:0] field_x,
  output logic [VAL_W-1:0] field_y,
  output logic [VAL_W-1:0] field_z
);

  localparam logic [IDX_W:0] NMAX_X = (IDX_W+1)'(NODES_X - 1);
  localparam logic [IDX_W:0] NMAX_Y = (IDX_W+1)'(NODES_Y - 1);
  localparam logic [IDX_W:0] NMAX_Z = (IDX_W+1)'(NODES_Z - 1);

  back_state_t state, state_next;

  logic [2:0]              cnt;
  logic [2:0][IDX_W-1:0]   lo;
  logic [2:0][FRAC_W-1:0]  frac;

  logic                    v1, l1, v2, l2, v3, l3, fin;
  logic [33:0]             p1;
  logic [FRAC_W-1:0]       wz1;
  logic [33:0]             w2;
  logic [3*VAL_W-1:0]      d2;
  logic signed [ACC_W-1:0] pr3 [3];
  logic signed [ACC_W-1:0] acc [3];
  logic [VAL_W-1:0]        res [3];

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_addr;
  logic [3*VAL_W-1:0]      ram_wdata;
  logic [3*VAL_W-1:0]      ram_rdata;

  logic [IDX_W:0]          sx, sy, sz;
  logic [IDX_W-1:0]        ix, iy, iz;
  logic [FRAC_W-1:0]       wx, wy, wz;
  logic [31:0]             lin;
  logic [50:0]             pw;

  tvf_ram #(
    .WIDTH (3*VAL_W),
    .DEPTH (STORE_D)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign q_pop = (state == BS_IDLE) && !q_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE:  if (q_pop && head.func == FUNC_QUERY) state_next = BS_RUN;
      BS_RUN:   if (cnt == 3'd7) state_next = BS_DRAIN;
      BS_DRAIN: if (fin) state_next = BS_IDLE;
      default:  state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    sx  = {1'b0, lo[0]} + (IDX_W+1)'(cnt[2]);
    sy  = {1'b0, lo[1]} + (IDX_W+1)'(cnt[1]);
    sz  = {1'b0, lo[2]} + (IDX_W+1)'(cnt[0]);
    ix  = IDX_W'((sx > NMAX_X) ? NMAX_X : sx);
    iy  = IDX_W'((sy > NMAX_Y) ? NMAX_Y : sy);
    iz  = IDX_W'((sz > NMAX_Z) ? NMAX_Z : sz);
    wx  = cnt[2] ? frac[0] : ONE_Q16 - frac[0];
    wy  = cnt[1] ? frac[1] : ONE_Q16 - frac[1];
    wz  = cnt[0] ? frac[2] : ONE_Q16 - frac[2];
    lin = (32'(ix) * 32'(NODES_Y) + 32'(iy)) * 32'(NODES_Z) + 32'(iz);
    pw  = 51'(p1) * 51'(wz1);
  end

  always_comb begin
    ram_we    = q_pop && (head.func == FUNC_LOAD);
    ram_wdata = {head.val[2], head.val[1], head.val[0]};
    ram_addr  = (state == BS_RUN) ? lin[ADDR_W-1:0] : head.node_addr;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [ACC_W-1:0] sum;
      logic signed [ACC_W-1:0] r;
      sum = acc[c] + (ACC_W'(1) << 31);
      r   = sum >>> 32;
      if (r > $signed(ACC_W'(32'h7FFF_FFFF))) begin
        res[c] = 32'h7FFF_FFFF;
      end else if (r < -$signed(ACC_W'(33'h0_8000_0000))) begin
        res[c] = 32'h8000_0000;
      end else begin
        res[c] = r[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      fin   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= (state == BS_RUN);
      v2    <= v1;
      v3    <= v2;
      fin   <= v3 && l3;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      lo   <= head.lo;
      frac <= head.frac;
      cnt  <= '0;
      for (int c = 0; c < 3; c++) begin
        acc[c] <= '0;
      end
    end else if (state == BS_RUN) begin
      cnt <= cnt + 3'd1;
    end
    l1  <= (cnt == 3'd7);
    p1  <= 34'(wx) * 34'(wy);
    wz1 <= wz;
    l2  <= l1;
    w2  <= pw[49:16];
    d2  <= ram_rdata;
    l3  <= l2;
    for (int c = 0; c < 3; c++) begin
      pr3[c] <= ACC_W'($signed(d2[c*VAL_W +: VAL_W])) * $signed(ACC_W'(w2));
    end
    if (v3) begin
      for (int c = 0; c < 3; c++) begin
        acc[c] <= acc[c] + pr3[c];
      end
    end
    if (fin) begin
      field_x <= res[0];
      field_y <= res[1];
      field_z <= res[2];
    end
  end

endmodule
